@@ rtl/sil_pkg.sv @@
// Shared constants and types for the serial image loader.
package sil_pkg;

	// Header is magic, length and checksum, each a little-endian 32-bit word.
	localparam logic [3:0]  HEADER_BYTES  = 4'd12;
	localparam logic [31:0] BOOT_MAGIC    = 32'h544F_4F42;
	localparam logic [31:0] BASE_AT_RESET = 32'h0008_0000;

	// Status codes carried with every result transaction.
	typedef enum logic [2:0] {
		ST_HEADER    = 3'd0,
		ST_PAYLOAD   = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_BAD_SUM   = 3'd3,
		ST_OK        = 3'd4
	} status_t;

endpackage

@@ rtl/serial_image_loader.sv @@
// Serial image loader: header parser, payload write generator and checksum check.
//
// The block takes one received byte per input transaction and returns exactly
// one result transaction for each. The first twelve bytes form a little-endian
// header (magic, payload length, expected checksum); a wrong magic is reported
// with the twelfth byte and header reception starts over. After a good header,
// each of the next length bytes comes out as a memory write to load_base plus
// its offset (wrapping at 2^32), and a 32-bit wrapping byte sum is kept. The
// last payload byte, or the last header byte when the length is zero, carries
// the verdict: loaded ok or bad checksum. An input transaction is accepted in
// every cycle in which the result register is empty or is being drained, so
// the sustained rate is one byte per clock while the output is not stalled, and
// each result is registered as its byte is accepted; the work per byte is one
// byte insert, three 32-bit adds (address, byte count and sum) and two 32-bit
// compares (count against length, sum against checksum), all between the state
// registers and the result register. The result register is the only buffer,
// so a stalled output holds the input side. load_base is written through
// cfg_we and cfg_wdata and should only change while no byte is in flight.
module serial_image_loader
	import sil_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // [0] wr_en, [32:1] wr_addr, [40:33] wr_data,
	                                // [43:41] status, [47:44] zero
	// Configuration: load_base.
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// Loader state.
	logic        phase_q;   // 0 header, 1 payload
	logic [3:0]  hcnt_q;
	logic [63:0] hs_q;      // magic in the low word, length in the high word
	logic [31:0] len_q;
	logic [31:0] exp_q;
	logic [31:0] pcnt_q;
	logic [31:0] sum_q;
	logic [31:0] base_q;

	// Result register.
	logic        m_valid_q;
	logic        en_q;
	logic [31:0] addr_q;
	logic [7:0]  data_q;
	status_t     st_q;

	// Next-state and result values.
	logic        phase_nx;
	logic [3:0]  hcnt_nx;
	logic [63:0] hs_nx;
	logic [31:0] len_nx;
	logic [31:0] exp_nx;
	logic [31:0] pcnt_nx;
	logic [31:0] sum_nx;
	logic        en_nx;
	logic [31:0] addr_nx;
	logic [7:0]  data_nx;
	status_t     st_nx;

	logic [63:0] hs_ins;
	logic [31:0] exp_ins;
	logic [31:0] exp_base;
	logic [3:0]  hc_inc;
	logic [31:0] pc_inc;
	logic [31:0] sum_add;
	logic        accept;

	// A new byte is taken whenever the result register is free or emptying.
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, st_q, data_q, addr_q, en_q};

	always_comb begin
		phase_nx = phase_q;
		hcnt_nx  = hcnt_q;
		hs_nx    = hs_q;
		len_nx   = len_q;
		exp_nx   = exp_q;
		pcnt_nx  = pcnt_q;
		sum_nx   = sum_q;
		en_nx    = 1'b0;
		addr_nx  = '0;
		data_nx  = '0;
		st_nx    = ST_HEADER;

		// Header byte insert: bytes 0 to 7 go to the shift word, 8 to 11 to the checksum.
		hs_ins   = hs_q;
		exp_base = (hcnt_q == 4'd8) ? 32'd0 : exp_q;
		exp_ins  = exp_q;
		for (int i = 0; i < 8; i++) begin
			if (!hcnt_q[3] && (hcnt_q[2:0] == i[2:0])) begin
				hs_ins[i*8 +: 8] = hs_q[i*8 +: 8] | s_tdata;
			end
		end
		if (hcnt_q[3]) begin
			exp_ins = exp_base;
			for (int k = 0; k < 4; k++) begin
				if (hcnt_q[1:0] == k[1:0]) begin
					exp_ins[k*8 +: 8] = exp_base[k*8 +: 8] | s_tdata;
				end
			end
		end
		hc_inc  = hcnt_q + 4'd1;
		pc_inc  = pcnt_q + 32'd1;
		sum_add = sum_q + {24'd0, s_tdata};

		if (!phase_q) begin
			exp_nx = exp_ins;
			if (hc_inc == HEADER_BYTES) begin
				len_nx  = hs_ins[63:32];
				hcnt_nx = '0;
				hs_nx   = '0;
				pcnt_nx = '0;
				sum_nx  = '0;
				if (hs_ins[31:0] != BOOT_MAGIC) begin
					st_nx = ST_BAD_MAGIC;
				end else if (hs_ins[63:32] == 32'd0) begin
					// Empty image: the sum is zero, so only a zero checksum passes.
					st_nx = (exp_ins == 32'd0) ? ST_OK : ST_BAD_SUM;
				end else begin
					phase_nx = 1'b1;
					st_nx    = ST_PAYLOAD;
				end
			end else begin
				hcnt_nx = hc_inc;
				hs_nx   = hs_ins;
			end
		end else begin
			en_nx   = 1'b1;
			addr_nx = base_q + pcnt_q;
			data_nx = s_tdata;
			if (pc_inc == len_q) begin
				st_nx    = (sum_add == exp_q) ? ST_OK : ST_BAD_SUM;
				phase_nx = 1'b0;
				hcnt_nx  = '0;
				hs_nx    = '0;
				pcnt_nx  = '0;
				sum_nx   = '0;
			end else begin
				st_nx   = ST_PAYLOAD;
				pcnt_nx = pc_inc;
				sum_nx  = sum_add;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			hcnt_q    <= '0;
			hs_q      <= '0;
			len_q     <= '0;
			exp_q     <= '0;
			pcnt_q    <= '0;
			sum_q     <= '0;
			base_q    <= BASE_AT_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q   <= phase_nx;
				hcnt_q    <= hcnt_nx;
				hs_q      <= hs_nx;
				len_q     <= len_nx;
				exp_q     <= exp_nx;
				pcnt_q    <= pcnt_nx;
				sum_q     <= sum_nx;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			en_q   <= en_nx;
			addr_q <= addr_nx;
			data_q <= data_nx;
			st_q   <= st_nx;
		end
	end

`ifndef ASSERT_OFF
	a_hdr_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q < HEADER_BYTES)
		else $error("header byte count out of range");

	a_payload_hdr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (hcnt_q == 4'd0 && hs_q == 64'd0))
		else $error("header state not cleared during payload");

	a_payload_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (pcnt_q != len_q))
		else $error("payload phase kept after last byte");

	a_write_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && en_q) |->
			(st_q == ST_PAYLOAD || st_q == ST_BAD_SUM || st_q == ST_OK))
		else $error("memory write with a header status");

	a_enter_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !phase_q && phase_nx) |=> (st_q == ST_PAYLOAD && !en_q))
		else $error("payload start not reported");
`endif

endmodule

@@ bench/sil_checker.sv @@
// Checker for the serial image loader: predicts each result and compares it.
module sil_checker
	import sil_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output int          results_owed,
	output int          mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Same layout as m_tdata, most significant field first.
	typedef struct packed {
		logic [3:0]  pad;
		status_t     status;
		logic [7:0]  data;
		logic [31:0] addr;
		logic        en;
	} load_result_t;

	// Shadow copy of the loader state.
	logic [31:0] base_addr;
	logic        in_payload;
	logic [3:0]  hdr_pos;
	logic [63:0] hdr_word;
	logic [31:0] body_len;
	logic [31:0] want_sum;
	logic [31:0] body_pos;
	logic [31:0] body_sum;

	load_result_t queued_results[$];

	function automatic void restart_header();
		in_payload = 1'b0;
		hdr_pos    = '0;
		hdr_word   = '0;
		body_pos   = '0;
		body_sum   = '0;
	endfunction

	// Advances the shadow state by one received byte and returns the result it causes.
	function automatic load_result_t take_byte(input logic [7:0] b);
		load_result_t r;
		logic [31:0] magic;
		r = '0;
		r.status = ST_HEADER;
		if (!in_payload) begin
			if (hdr_pos < 8) begin
				hdr_word = hdr_word | ({56'd0, b} << (hdr_pos * 8));
			end else begin
				if (hdr_pos == 8)
					want_sum = '0;
				want_sum = want_sum | ({24'd0, b} << ((hdr_pos - 8) * 8));
			end
			hdr_pos = hdr_pos + 4'd1;
			if (hdr_pos >= HEADER_BYTES) begin
				magic    = hdr_word[31:0];
				body_len = hdr_word[63:32];
				if (magic != BOOT_MAGIC) begin
					r.status = ST_BAD_MAGIC;
					restart_header();
				end else if (body_len == 0) begin
					// Empty image: the verdict compares an empty sum.
					restart_header();
					r.status = (body_sum == want_sum) ? ST_OK : ST_BAD_SUM;
				end else begin
					restart_header();
					in_payload = 1'b1;
					r.status   = ST_PAYLOAD;
				end
			end
		end else begin
			r.en     = 1'b1;
			r.addr   = base_addr + body_pos;
			r.data   = b;
			body_sum = body_sum + {24'd0, b};
			body_pos = body_pos + 32'd1;
			if (body_pos == body_len) begin
				r.status = (body_sum == want_sum) ? ST_OK : ST_BAD_SUM;
				restart_header();
			end else begin
				r.status = ST_PAYLOAD;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		load_result_t got;
		load_result_t exp;
		if (!arst_n) begin
			base_addr = BASE_AT_RESET;
			restart_header();
			body_len = '0;
			want_sum = '0;
			queued_results.delete();
			results_owed   <= 0;
			mismatch_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (queued_results.size() == 0) begin
					$display("%0t: result with nothing expected, got en=%0d addr=%h data=%h status=%0d",
						$time, got.en, got.addr, got.data, got.status);
					mismatch_count++;
				end else begin
					exp = queued_results.pop_front();
					if (got.en !== exp.en || got.addr !== exp.addr ||
					    got.data !== exp.data || got.status !== exp.status) begin
						$display("%0t: mismatch, expected en=%0d addr=%h data=%h status=%0d",
							$time, exp.en, exp.addr, exp.data, exp.status);
						$display("%0t:           actual en=%0d addr=%h data=%h status=%0d",
							$time, got.en, got.addr, got.data, got.status);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				queued_results.push_back(take_byte(s_tdata));
			if (cfg_we)
				base_addr = cfg_wdata;
			results_owed <= queued_results.size();
		end
	end

endmodule

@@ bench/tb_serial_image_loader.sv @@
// Testbench top for the serial image loader: stimulus, idling and verdict.
module tb_serial_image_loader;
	timeunit 1ns;
	timeprecision 1ps;
	import sil_pkg::*;

	// The limit leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 200000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;    // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;           // [0] wr_en, [32:1] wr_addr, [40:33] wr_data,
	                                // [43:41] status, [47:44] zero
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	int results_owed;
	int mismatch_count;

	// Idle rates in percent per cycle for the byte source and the result sink.
	int src_idle = 0;
	int dst_idle = 0;

	// Bookkeeping for the phase shares, the watchdog and the closing summary.
	int bytes_sent    = 0;
	int n_clean       = 0;
	int n_bad_sum     = 0;
	int n_bad_magic   = 0;
	int n_empty       = 0;
	int n_rebase      = 0;
	int n_rebase_mid  = 0;
	int cycle_count   = 0;

	serial_image_loader dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sil_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.results_owed  (results_owed),
		.mismatch_count(mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result sink stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= (dst_idle == 0) || ($urandom_range(99) >= dst_idle);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one byte and returns at the edge where the transaction completes.
	// The valid stays high afterwards so that back-to-back bytes need no toggle;
	// it is lowered only when the source idles or the stream is drained.
	task automatic send_byte(input logic [7:0] b);
		if (src_idle != 0 && $urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
	endtask

	// Stops offering bytes and waits until every predicted result has been seen.
	// The checker publishes its count through a register, hence the leading edge.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes load_base while the loader has nothing in flight.
	task automatic write_base(input logic [31:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		n_rebase++;
	endtask

	// Sends the twelve header bytes, each word little-endian.
	task automatic send_header(input logic [31:0] magic, input logic [31:0] len,
	                           input logic [31:0] sum);
		logic [95:0] hdr;
		hdr = {sum, len, magic};
		for (int i = 0; i < 12; i++)
			send_byte(hdr[i*8 +: 8]);
	endtask

	// One random frame: mostly loads of random content, some with a bad checksum;
	// the rest are empty images and headers whose magic is wrong, often by one bit.
	task automatic send_frame();
		int          roll;
		int          cut;
		logic [31:0] len;
		logic [31:0] sum;
		logic [31:0] magic;
		logic [7:0]  body [0:95];
		roll = $urandom_range(99);
		if (roll < 12) begin
			magic = $urandom;
			if ($urandom_range(1) == 1)
				magic = BOOT_MAGIC ^ (32'd1 << $urandom_range(31));
			if (magic == BOOT_MAGIC)
				magic[0] = ~magic[0];
			send_header(magic, $urandom, $urandom);
			n_bad_magic++;
		end else if (roll < 22) begin
			// Empty image: only a zero checksum is accepted.
			sum = ($urandom_range(1) == 1) ? 32'd0 : $urandom;
			send_header(BOOT_MAGIC, 32'd0, sum);
			n_empty++;
		end else begin
			len = (roll < 30) ? $urandom_range(96, 25) : $urandom_range(24, 1);
			sum = '0;
			for (int i = 0; i < len; i++) begin
				body[i] = $urandom;
				sum = sum + {24'd0, body[i]};
			end
			if ($urandom_range(99) < 30) begin
				sum = sum ^ ((32'd1 << $urandom_range(31)) | $urandom);
				n_bad_sum++;
			end else begin
				n_clean++;
			end
			// Now and then the base moves in the middle of a load.
			cut = (len >= 2 && $urandom_range(99) < 8) ? $urandom_range(len - 1, 1) : -1;
			send_header(BOOT_MAGIC, len, sum);
			for (int i = 0; i < len; i++) begin
				if (i == cut) begin
					write_base($urandom);
					n_rebase_mid++;
				end
				send_byte(body[i]);
			end
		end
	endtask

	// A phase sets its own base and idle rates and then runs frames until its
	// share of bytes has gone out.
	task automatic run_phase(input int src, input int dst, input logic [31:0] base,
	                         input int share);
		int start;
		write_base(base);
		src_idle = src;
		dst_idle = dst;
		start    = bytes_sent;
		while (bytes_sent - start < share)
			send_frame();
	endtask

	initial begin
		// Reset is held at the start and released once.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 10;
		dst_idle = 56;

		// Directed part. A three-byte image with base at the top of the address
		// space: the first write lands on the last address, the second wraps to
		// zero, then the base moves to zero before the third byte. The bytes hit
		// both extremes and the checksum matches.
		write_base(32'hFFFF_FFFF);
		send_header(BOOT_MAGIC, 32'd3, 32'h0000_0141);
		send_byte(8'hFF);
		send_byte(8'h00);
		write_base(32'h0000_0000);
		n_rebase_mid++;
		send_byte(8'h42);
		n_clean++;
		// An empty image with a zero checksum is reported on the last header byte.
		send_header(BOOT_MAGIC, 32'd0, 32'd0);
		n_empty++;

		// Random part in three idling phases; the base is low, high, then random.
		run_phase(10, 56, 32'h0000_0000, 230);
		run_phase(56, 10, 32'hFFFF_FFF0, 230);
		run_phase(0, 0, $urandom, 200);

		// Close with a load whose length has its top bit set; it cannot finish,
		// so the loader is left in the middle of the payload.
		send_header(BOOT_MAGIC, 32'h8000_0000 | $urandom, $urandom);
		repeat (20) send_byte($urandom);

		wait_drained();
		repeat (4) @(posedge clk);

		$display("Sent %0d bytes: %0d good loads, %0d bad checksums,", bytes_sent, n_clean,
			n_bad_sum);
		$display("%0d bad magics, %0d empty images; load_base written %0d times, %0d mid-load.",
			n_bad_magic, n_empty, n_rebase, n_rebase_mid);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/sil_pkg.sv
rtl/serial_image_loader.sv
bench/sil_checker.sv
bench/tb_serial_image_loader.sv
